### src/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// types, codes and helper functions shared by the display dimmer blocks
// ----------------------------------------------------------------------------
`default_nettype none

package sdd_pkg;

  // command codes carried in the opcode field
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_LEVEL  = 3'd1,
    OP_SET_DARK   = 3'd2,
    OP_RESUME     = 3'd3,
    OP_WRITE_RULE = 3'd4
  } op_e;

  // configuration register indexes
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_RULE_COUNT    = 1'b1;

  // result status codes
  localparam logic STAT_APPLIED = 1'b0;
  localparam logic STAT_REFUSED = 1'b1;

  localparam int unsigned LVL_W    = 7;
  localparam int unsigned MIN_W    = 11;
  localparam int unsigned RULE_W   = 2 * MIN_W + LVL_W;
  localparam logic [LVL_W-1:0] LEVEL_MIN = 7'd5;
  localparam logic [LVL_W-1:0] LEVEL_MAX = 7'd100;

  // rule table write
  typedef struct packed {
    logic             we;
    logic [6:0]       idx;
    logic [MIN_W-1:0] start_min;
    logic [MIN_W-1:0] end_min;
    logic [LVL_W-1:0] value;
  } rule_wr_t;

  // scan request and answer
  typedef struct packed {
    logic             start;
    logic [MIN_W-1:0] now;
    logic [7:0]       count;
  } scan_req_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [LVL_W-1:0] value;
  } scan_rsp_t;

  // channel store control
  typedef struct packed {
    logic lvl_we;
    logic rd_en;
    logic dark_we;
    logic dark_val;
  } chan_ctl_t;

  function automatic logic [LVL_W-1:0] clamp_pct(input logic [LVL_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = v;
    if (v < LEVEL_MIN) r = LEVEL_MIN;
    else if (v > LEVEL_MAX) r = LEVEL_MAX;
    return r;
  endfunction

  // round to nearest multiple of five, halves up; divide by 5 via 205/1024
  function automatic logic [LVL_W-1:0] snap_pct(input logic [LVL_W-1:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [LVL_W-1:0] m;
    prod = (16'(v) + 16'd2) * 16'd205;
    q    = prod[14:10];
    m    = 7'({q, 2'b00}) + 7'(q);
    return clamp_pct(m);
  endfunction

  // overlay opacity; x / 100 done as x * 5243 >> 19, exact for x below 2^15
  function automatic logic [7:0] alpha_of(input logic [LVL_W-1:0] b, input logic dark);
    logic [LVL_W-1:0] d;
    logic [14:0]      x;
    logic [27:0]      prod;
    d    = LEVEL_MAX - b;
    x    = (15'(d) << 8) - 15'(d);
    prod = 28'(x) * 28'd5243;
    return dark ? 8'hFF : prod[26:19];
  endfunction

endpackage

`default_nettype wire

### src/sdd_if.sv
// ----------------------------------------------------------------------------
// sdd_in_if / sdd_out_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface sdd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  channel;
  logic [6:0]  level;
  logic        enable;
  logic [10:0] now_minute;
  logic [6:0]  rule_index;
  logic [10:0] rule_start;
  logic [10:0] rule_end;

  modport source (
    output valid, opcode, channel, level, enable, now_minute, rule_index,
           rule_start, rule_end,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, level, enable, now_minute, rule_index,
           rule_start, rule_end,
    output ready
  );
endinterface

interface sdd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_channel;
  logic [6:0] out_brightness;
  logic       out_blackout;
  logic [7:0] alpha;
  logic       status;
  logic       manual_mode;
  logic       last;

  modport source (
    output valid, out_channel, out_brightness, out_blackout, alpha, status,
           manual_mode, last,
    input  ready
  );
  modport sink (
    input  valid, out_channel, out_brightness, out_blackout, alpha, status,
           manual_mode, last,
    output ready
  );
endinterface

`default_nettype wire

### src/sdd_rule_scan.sv
// ----------------------------------------------------------------------------
// sdd_rule_scan
// schedule rule memory and first-match scanner, one rule per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sdd_rule_scan
  import sdd_pkg::*;
#(
  parameter int unsigned MAX_RULE_ENTRIES = 128
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  rule_wr_t   wr_i,
  input  scan_req_t  req_i,
  output scan_rsp_t  rsp_o
);

  localparam int unsigned RI_W = (MAX_RULE_ENTRIES > 1) ? $clog2(MAX_RULE_ENTRIES) : 1;

  logic [RULE_W-1:0] mem [MAX_RULE_ENTRIES];
  logic [RULE_W-1:0] rd_data_q;
  logic [RI_W-1:0]   rd_addr;
  logic              rd_en;
  logic              wr_ok;

  logic             run_q;
  logic [7:0]       nxt_q;
  logic [7:0]       cnt_q;
  logic [MIN_W-1:0] now_q;

  logic [MIN_W-1:0] r_start;
  logic [MIN_W-1:0] r_end;
  logic [LVL_W-1:0] r_value;
  logic             match;
  logic             exhausted;

  assign r_start = rd_data_q[RULE_W-1 -: MIN_W];
  assign r_end   = rd_data_q[LVL_W +: MIN_W];
  assign r_value = rd_data_q[LVL_W-1:0];

  // wrapped range when start is not below end
  always_comb begin
    if (r_start < r_end) begin
      match = (now_q >= r_start) && (now_q <= r_end);
    end else begin
      match = (now_q >= r_start) || (now_q <= r_end);
    end
  end

  assign exhausted = (nxt_q >= cnt_q);
  assign rd_en     = req_i.start || (run_q && !match && !exhausted);
  assign rd_addr   = req_i.start ? '0 : RI_W'(nxt_q);
  assign wr_ok     = wr_i.we && (32'(wr_i.idx) < 32'(MAX_RULE_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[RI_W'(wr_i.idx)] <= {wr_i.start_min, wr_i.end_min, wr_i.value};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      nxt_q <= '0;
      cnt_q <= '0;
      now_q <= '0;
    end else if (req_i.start) begin
      run_q <= 1'b1;
      nxt_q <= 8'd1;
      cnt_q <= req_i.count;
      now_q <= req_i.now;
    end else if (run_q) begin
      if (match || exhausted) begin
        run_q <= 1'b0;
      end else begin
        nxt_q <= nxt_q + 8'd1;
      end
    end
  end

  assign rsp_o.done  = run_q && (match || exhausted);
  assign rsp_o.hit   = run_q && match;
  assign rsp_o.value = r_value;

endmodule

`default_nettype wire

### src/sdd_chan_store.sv
// ----------------------------------------------------------------------------
// sdd_chan_store
// per-channel brightness memory with valid bits, and blackout flags
// ----------------------------------------------------------------------------
`default_nettype none

module sdd_chan_store
  import sdd_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 16,
  localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  chan_ctl_t               ctl_i,
  input  wire [CH_W-1:0]          wr_addr_i,
  input  wire [LVL_W-1:0]         wr_level_i,
  input  wire [CH_W-1:0]          rd_addr_i,
  output logic [LVL_W-1:0]        rd_level_o,
  output logic [MAX_CHANNELS-1:0] dark_o
);

  logic [LVL_W-1:0]        mem [MAX_CHANNELS];
  logic [LVL_W-1:0]        rd_q;
  logic                    rd_valid_q;
  logic [MAX_CHANNELS-1:0] valid_q;
  logic [MAX_CHANNELS-1:0] dark_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.lvl_we) begin
      mem[wr_addr_i] <= wr_level_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      dark_q     <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.lvl_we) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.dark_we) begin
        dark_q[wr_addr_i] <= ctl_i.dark_val;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never-written entries read as full brightness
  assign rd_level_o = rd_valid_q ? rd_q : LEVEL_MAX;
  assign dark_o     = dark_q;

endmodule

`default_nettype wire

### src/scheduled_display_dimmer_core.sv
// ----------------------------------------------------------------------------
// scheduled_display_dimmer_core
// multi-channel dimming controller with manual override and time-of-day rules
// ----------------------------------------------------------------------------
// sequence: set brightness goes to the output register; set blackout first
//   reads the level memory; tick reads rules one per cycle from the rule memory
//   up to the first match, then writes and reports channels one per free output slot
// throughput: one command at a time; the next beat is taken once the last
//   result of the previous one sits in the output register; output stalls delay it
// reset: brightness 100, blackout off, override clear, channel_count 1, rule_count 0
// ----------------------------------------------------------------------------
`default_nettype none

module scheduled_display_dimmer_core
  import sdd_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS     = 16,
  parameter int unsigned MAX_RULE_ENTRIES = 128
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire        cfg_idx_i,
  input  wire [7:0]  cfg_data_i,
  sdd_in_if.sink     in_ch,
  sdd_out_if.source  out_ch
);

  localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_RD,
    ST_EMIT
  } state_e;

  // configuration registers
  logic [4:0] cc_q;
  logic [7:0] rc_q;
  logic [4:0] chans;
  logic [7:0] nrules;

  // sequencer state
  state_e           state_q, state_d;
  logic             ovr_q, ovr_d;
  logic [3:0]       ch_q, ch_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic             stat_q, stat_d;
  logic [4:0]       cnt_q, cnt_d;

  // output register
  logic             out_valid_q;
  logic [3:0]       out_ch_q;
  logic [LVL_W-1:0] out_lvl_q;
  logic             out_dark_q;
  logic [7:0]       out_alpha_q;
  logic             out_stat_q;
  logic             out_man_q;
  logic             out_last_q;

  // emit path into the output register
  logic             emit_en;
  logic [3:0]       emit_ch;
  logic [LVL_W-1:0] emit_lvl;
  logic             emit_dark;
  logic             emit_stat;
  logic             emit_last;
  logic             out_free;

  logic             accept;
  logic             ch_ok;
  logic             all_dark;
  logic             refuse;

  // submodule links
  rule_wr_t                rule_wr;
  scan_req_t               scan_req;
  scan_rsp_t               scan_rsp;
  chan_ctl_t               chan_ctl;
  logic [CH_W-1:0]         wr_addr;
  logic [LVL_W-1:0]        wr_level;
  logic [CH_W-1:0]         rd_addr;
  logic [LVL_W-1:0]        rd_level;
  logic [MAX_CHANNELS-1:0] dark_vec;

  // counts above the build limits act as the limits
  assign chans  = (32'(cc_q) > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : cc_q;
  assign nrules = (32'(rc_q) > MAX_RULE_ENTRIES) ? 8'(MAX_RULE_ENTRIES) : rc_q;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_q || out_ch.ready;
  assign ch_ok       = ({1'b0, in_ch.channel} < chans);

  // blackout is refused when every other channel in use is already dark
  always_comb begin
    all_dark = 1'b1;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if ((32'(c) < 32'(chans)) && (32'(c) != 32'(in_ch.channel)) && !dark_vec[c]) begin
        all_dark = 1'b0;
      end
    end
  end
  assign refuse = in_ch.enable && all_dark;

  // rule writes go straight to the rule memory
  assign rule_wr.we        = accept && (op_e'(in_ch.opcode) == OP_WRITE_RULE);
  assign rule_wr.idx       = in_ch.rule_index;
  assign rule_wr.start_min = in_ch.rule_start;
  assign rule_wr.end_min   = in_ch.rule_end;
  assign rule_wr.value     = clamp_pct(in_ch.level);

  assign rd_addr = CH_W'(in_ch.channel);

  always_comb begin
    state_d   = state_q;
    ovr_d     = ovr_q;
    ch_d      = ch_q;
    lvl_d     = lvl_q;
    stat_d    = stat_q;
    cnt_d     = cnt_q;
    scan_req  = '{start: 1'b0, now: in_ch.now_minute, count: nrules};
    chan_ctl  = '0;
    wr_addr   = CH_W'(in_ch.channel);
    wr_level  = snap_pct(in_ch.level);
    emit_en   = 1'b0;
    emit_ch   = ch_q;
    emit_lvl  = lvl_q;
    emit_dark = dark_vec[CH_W'(ch_q)];
    emit_stat = stat_q;
    emit_last = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ch_d = in_ch.channel;
          case (op_e'(in_ch.opcode)) inside
            OP_TICK, OP_RESUME: begin
              if (op_e'(in_ch.opcode) == OP_RESUME) begin
                ovr_d = 1'b0;
              end
              // no result when held by override, no rules or no channels
              if ((nrules != 8'd0) && (chans != 5'd0) &&
                  (!ovr_q || in_ch.enable || (op_e'(in_ch.opcode) == OP_RESUME))) begin
                scan_req.start = 1'b1;
                state_d        = ST_SCAN;
              end
            end
            OP_SET_LEVEL: begin
              if (ch_ok) begin
                chan_ctl.lvl_we = 1'b1;
                ovr_d           = 1'b1;
                lvl_d           = snap_pct(in_ch.level);
                stat_d          = STAT_APPLIED;
                state_d         = ST_EMIT;
              end
            end
            OP_SET_DARK: begin
              if (ch_ok) begin
                chan_ctl.rd_en = 1'b1;
                if (refuse) begin
                  stat_d = STAT_REFUSED;
                end else begin
                  chan_ctl.dark_we  = 1'b1;
                  chan_ctl.dark_val = in_ch.enable;
                  ovr_d             = 1'b1;
                  stat_d            = STAT_APPLIED;
                end
                state_d = ST_RD;
              end
            end
            default: begin
              // rule writes and unused codes give no result
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          if (scan_rsp.hit) begin
            lvl_d   = clamp_pct(scan_rsp.value);
            cnt_d   = '0;
            stat_d  = STAT_APPLIED;
            state_d = ST_FILL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FILL: begin
        // write and report one channel per free output slot
        wr_addr   = CH_W'(cnt_q);
        wr_level  = lvl_q;
        emit_ch   = 4'(cnt_q);
        emit_dark = dark_vec[CH_W'(cnt_q)];
        emit_last = (cnt_q == chans - 5'd1);
        if (out_free) begin
          emit_en         = 1'b1;
          chan_ctl.lvl_we = 1'b1;
          cnt_d           = cnt_q + 5'd1;
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        lvl_d   = rd_level;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_en = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ovr_q       <= 1'b0;
      ch_q        <= '0;
      lvl_q       <= '0;
      stat_q      <= STAT_APPLIED;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_ch_q    <= '0;
      out_lvl_q   <= '0;
      out_dark_q  <= 1'b0;
      out_alpha_q <= '0;
      out_stat_q  <= STAT_APPLIED;
      out_man_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovr_q   <= ovr_d;
      ch_q    <= ch_d;
      lvl_q   <= lvl_d;
      stat_q  <= stat_d;
      cnt_q   <= cnt_d;
      if (emit_en) begin
        out_valid_q <= 1'b1;
        out_ch_q    <= emit_ch;
        out_lvl_q   <= emit_lvl;
        out_dark_q  <= emit_dark;
        out_alpha_q <= alpha_of(emit_lvl, emit_dark);
        out_stat_q  <= emit_stat;
        out_man_q   <= ovr_q;
        out_last_q  <= emit_last;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= 5'd1;
      rc_q <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CHANNEL_COUNT: cc_q <= cfg_data_i[4:0];
        REG_RULE_COUNT:    rc_q <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.out_channel    = out_ch_q;
  assign out_ch.out_brightness = out_lvl_q;
  assign out_ch.out_blackout   = out_dark_q;
  assign out_ch.alpha          = out_alpha_q;
  assign out_ch.status         = out_stat_q;
  assign out_ch.manual_mode    = out_man_q;
  assign out_ch.last           = out_last_q;

  sdd_rule_scan #(
    .MAX_RULE_ENTRIES (MAX_RULE_ENTRIES)
  ) u_rule_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (rule_wr),
    .req_i  (scan_req),
    .rsp_o  (scan_rsp)
  );

  sdd_chan_store #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_chan_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (chan_ctl),
    .wr_addr_i  (wr_addr),
    .wr_level_i (wr_level),
    .rd_addr_i  (rd_addr),
    .rd_level_o (rd_level),
    .dark_o     (dark_vec)
  );

  // a new beat never overwrites a result that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_en |-> (!out_valid_q || out_ch.ready))
    else $error("result register overwritten while held");

  // reported brightness always within 5..100
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_lvl_q >= LEVEL_MIN) && (out_lvl_q <= LEVEL_MAX)))
    else $error("brightness out of range");

  // a refusal is a single-result command
  a_refuse_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_stat_q == STAT_REFUSED)) |-> out_last_q)
    else $error("refusal not marked last");

  // scanner answers only while a tick waits for it
  a_scan_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_rsp.done |-> (state_q == ST_SCAN))
    else $error("scan answer outside scan state");

  // fill sweep stays within the channels in use
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (cnt_q < chans))
    else $error("fill counter past channel count");

endmodule

`default_nettype wire
